@@ rtl/pci_pkg.sv @@
// Shared constants and types for the palette color indexer.
// Used by the cell, the cell row and the top level; no dependencies.
`timescale 1ns / 1ps

package pci_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES + 1);

  localparam logic [31:0] REDUCE_MASK = 32'h00F8_F8F8;

  typedef logic [CNT_W-1:0] cnt_t;

  // A pixel request as it travels along the row of cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] color;
    logic        found;
    logic        added;
    cnt_t        idx;
  } token_t;

endpackage

@@ rtl/pci_cell.sv @@
// One palette cell: holds one palette entry and one stage of the request token.
// Depends on pci_pkg.
`timescale 1ns / 1ps

module pci_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  pci_pkg::cnt_t   cell_idx_i,
  input  pci_pkg::cnt_t   count_i,
  input  pci_pkg::token_t tok_i,
  output pci_pkg::token_t tok_o
);

  pci_pkg::token_t tok_d, tok_q;
  logic [31:0]     entry_q;
  logic            wr;

  always_comb begin
    tok_d = tok_i;
    wr    = 1'b0;
    if (tok_i.valid && !tok_i.found) begin
      if ((cell_idx_i < count_i) && (entry_q == tok_i.color)) begin
        tok_d.found = 1'b1;
        tok_d.idx   = cell_idx_i;
      end else if (cell_idx_i == count_i) begin
        tok_d.found = 1'b1;
        tok_d.added = 1'b1;
        tok_d.idx   = cell_idx_i;
        wr          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wr) begin
      entry_q <= tok_i.color;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/pci_chain.sv @@
// Row of palette cells; each cell hands the request token to the next one.
// Depends on pci_pkg and pci_cell.
`timescale 1ns / 1ps

module pci_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  pci_pkg::cnt_t   count_i,
  input  pci_pkg::token_t tok_i,
  output pci_pkg::token_t tok_o
);

  pci_pkg::token_t link [pci_pkg::PALETTE_ENTRIES+1];

  assign link[0] = tok_i;

  for (genvar g = 0; g < pci_pkg::PALETTE_ENTRIES; g++) begin : g_cell
    pci_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv_i),
      .cell_idx_i (pci_pkg::CNT_W'(g)),
      .count_i    (count_i),
      .tok_i      (link[g]),
      .tok_o      (link[g+1])
    );
  end

  assign tok_o = link[pci_pkg::PALETTE_ENTRIES];

endmodule

@@ rtl/palette_color_indexer_top.sv @@
// Top level of the palette color indexer: stream ports, color count, output register.
// Depends on pci_pkg and pci_chain.
// One pixel at a time walks as a token through the row of palette cells; a new pixel is
// taken once the last result is captured into the output register, also while it waits.
// Reset clears the color count, the reduce mode and the handshake state, not the palette.
`timescale 1ns / 1ps

module palette_color_indexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // reduce_colors
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i, // [31:0] pixel_color
  input  logic [0:0]  s_axis_tuser_i, // [0] clear_first
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o, // [7:0] color_index, [16:8] colors_in_use
  output logic [1:0]  m_axis_tuser_o  // [0] was_added, [1] overflowed
);

  logic            reduce_q;
  logic            busy_q;
  pci_pkg::cnt_t   count_q, count_d;
  pci_pkg::token_t inj_q, inj_d;
  pci_pkg::token_t last;
  logic            in_acc, out_free, capture, adv;
  logic            out_valid_q;
  logic [7:0]      idx_q;
  logic [8:0]      used_q;
  logic            added_q, over_q;
  logic [31:0]     idx_ext, used_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduce_q <= 1'b0;
    end else if (cfg_valid_i) begin
      reduce_q <= cfg_data_i;
    end
  end

  assign s_axis_tready_o = !busy_q;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign capture  = last.valid && out_free;
  assign adv      = !(last.valid && !out_free);

  always_comb begin
    inj_d       = '0;
    inj_d.valid = in_acc;
    inj_d.color = reduce_q ? (s_axis_tdata_i & pci_pkg::REDUCE_MASK) : s_axis_tdata_i;
  end

  always_comb begin
    count_d = count_q;
    if (in_acc && s_axis_tuser_i[0]) begin
      count_d = '0;
    end else if (capture && last.added) begin
      count_d = count_q + pci_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      inj_q   <= '0;
    end else begin
      count_q <= count_d;
      inj_q   <= inj_d;
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (capture) begin
        busy_q <= 1'b0;
      end
    end
  end

  pci_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .count_i (count_q),
    .tok_i   (inj_q),
    .tok_o   (last)
  );

  assign idx_ext  = last.found ? 32'(last.idx) : 32'd0;
  assign used_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (capture) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      idx_q   <= idx_ext[7:0];
      used_q  <= used_ext[8:0];
      added_q <= last.added;
      over_q  <= !last.found;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, used_q, idx_q};
  assign m_axis_tuser_o  = {over_q, added_q};

endmodule

@@ test/palette_color_indexer_top_tb.sv @@
// Self-checking testbench for palette_color_indexer_top: directed and random pixel streams.
// Depends on pci_pkg and the palette_color_indexer_top RTL; a scoreboard class predicts
// every palette index.
`timescale 1ns / 1ps

module palette_color_indexer_top_tb;

  localparam int unsigned MAX_GAP = 13;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = pci_pkg::PALETTE_ENTRIES + 40;
  localparam int unsigned FILL_FRESH = 270;

  typedef enum int { MIX_TRAFFIC, FILL_TRAFFIC } traffic_e;

  typedef struct packed {
    logic [7:0] color_index;
    logic       was_added;
    logic       overflowed;
    logic [8:0] colors_in_use;
  } index_result_t;

  class palette_scoreboard;
    logic [31:0]   entries [pci_pkg::PALETTE_ENTRIES];
    int unsigned   filled;
    bit            reduce;
    int unsigned   errors;
    index_result_t awaited [$];

    function void note_pixel(logic [31:0] pixel, logic clear);
      logic [31:0]   color;
      index_result_t r;
      bit            hit;
      int unsigned   i;
      r = '0;
      hit = 1'b0;
      if (clear) filled = 0;
      color = reduce ? (pixel & pci_pkg::REDUCE_MASK) : pixel;
      for (i = 0; i < filled; i++) begin
        if (!hit && entries[i] == color) begin
          hit = 1'b1;
          r.color_index = 8'(i);
        end
      end
      if (!hit) begin
        if (filled < pci_pkg::PALETTE_ENTRIES) begin
          entries[filled] = color;
          r.color_index = 8'(filled);
          r.was_added = 1'b1;
          filled++;
        end else begin
          r.overflowed = 1'b1;
        end
      end
      r.colors_in_use = 9'(filled);
      awaited.push_back(r);
    endfunction

    task report(string what);
      $display("%0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [23:0] data, logic [1:0] user);
      index_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with no request pending: data=%h user=%b", data, user));
        return;
      end
      want = awaited.pop_front();
      if (data[7:0] !== want.color_index)
        report($sformatf("color_index %h, want %h", data[7:0], want.color_index));
      if (data[16:8] !== want.colors_in_use)
        report($sformatf("colors_in_use %0d, want %0d", data[16:8], want.colors_in_use));
      if (user[0] !== want.was_added)
        report($sformatf("was_added %b, want %b", user[0], want.was_added));
      if (user[1] !== want.overflowed)
        report($sformatf("overflowed %b, want %b", user[1], want.overflowed));
    endtask

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  palette_scoreboard sb = new;
  logic [31:0]       pool [$];
  int unsigned       src_max_gap;
  int unsigned       snk_max_gap;
  int unsigned       idle_cycles;

  palette_color_indexer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned gap;
    m_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = $urandom_range(snk_max_gap, 0);
      @(negedge clk_i);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
    end
  end

  task automatic hold_pixels();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
  endtask

  task automatic await_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [31:0] color, input logic clear);
    int unsigned gap;
    gap = $urandom_range(src_max_gap, 0);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= color;
    s_tuser <= clear;
    do @(posedge clk_i); while (!s_tready);
    sb.note_pixel(color, clear);
  endtask

  task automatic write_reduce(input logic mode);
    hold_pixels();
    await_results();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    sb.reduce = mode;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] mixed_color();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (pool.size() > 0 && roll < 50) return pool[$urandom_range(pool.size() - 1, 0)];
    if (pool.size() > 0 && roll < 65)
      return pool[$urandom_range(pool.size() - 1, 0)] ^ ($urandom() & ~pci_pkg::REDUCE_MASK);
    if (roll < 70) return 32'h0000_0000;
    if (roll < 75) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic run_traffic(input traffic_e kind, input int unsigned count);
    logic [31:0] color;
    logic        clear;
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (kind == FILL_TRAFFIC) begin
        clear = (k == 0);
        if (k < FILL_FRESH || pool.size() == 0 || $urandom_range(1, 0) == 0)
          color = $urandom();
        else
          color = pool[$urandom_range(pool.size() - 1, 0)];
      end else begin
        clear = ($urandom_range(29, 0) == 0);
        color = mixed_color();
        if ($urandom_range(49, 0) == 0) begin
          hold_pixels();
          await_results();
        end
      end
      send_pixel(color, clear);
      if (clear) pool.delete();
      pool.push_back(color);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    idle_cycles = 0;
    src_max_gap = MAX_GAP;
    snk_max_gap = MAX_GAP;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reduce(1'b0);
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFF8, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_0000, 1'b1);
    write_reduce(1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0707_0707, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'hAAFF_FFFF, 1'b0);
    send_pixel(32'h0000_0007, 1'b0);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h1234_5670, 1'b0);
    write_reduce(1'b0);
    send_pixel(32'h00F8_F8F8, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);

    run_traffic(MIX_TRAFFIC, 300);
    src_max_gap = 0;
    snk_max_gap = 0;
    run_traffic(FILL_TRAFFIC, 300);
    write_reduce(1'b1);
    src_max_gap = MAX_GAP;
    snk_max_gap = MAX_GAP;
    run_traffic(FILL_TRAFFIC, 300);
    snk_max_gap = 0;
    run_traffic(MIX_TRAFFIC, 300);
    write_reduce(1'b0);
    src_max_gap = 0;
    snk_max_gap = MAX_GAP;
    run_traffic(MIX_TRAFFIC, 300);

    hold_pixels();
    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
